[rtl/core/nmea_zda_sentence_parser_core_macros.svh]
// Assertion helpers for the checker file of the time sentence parser.
`ifndef NMEA_ZDA_SENTENCE_PARSER_CORE_MACROS_SVH
`define NMEA_ZDA_SENTENCE_PARSER_CORE_MACROS_SVH

// Same-cycle implication, reset aware.
`define NZP_ASSERT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset aware.
`define NZP_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/nzp_pkg.sv]
`default_nettype none

package nzp_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int POS_W = $clog2(BUFFER_DEPTH + 1);

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_NONE = 8'h00;

	localparam logic [3:0] STEP_DONE = 4'd12;

	// "$GPZDA" is the first six characters of the no-fix pattern
	localparam int ZDA_LEN = 6;
	localparam int NOFIX_LEN = 16;
	localparam logic [7:0] NOFIX_TAG [NOFIX_LEN] = '{
		8'h24, 8'h47, 8'h50, 8'h5A, 8'h44, 8'h41, 8'h2C, 8'h2C,
		8'h2C, 8'h2C, 8'h2C, 8'h30, 8'h30, 8'h2C, 8'h30, 8'h30
	};

	localparam int TIME_FIELDS = 5;
	localparam logic [2:0] SLOT_YEAR = 3'd5;
	localparam logic [2:0] SLOT_NONE = 3'd6;

	typedef enum logic [1:0] {
		STATUS_TIME_OK   = 2'd0,
		STATUS_NO_FIX    = 2'd1,
		STATUS_MALFORMED = 2'd2,
		STATUS_OTHER     = 2'd3
	} status_t;

	// Parse steps of "$GPZDA,hhmmss.ff,dd,mm,yyyy" after the tag
	function automatic logic [7:0] step_lit(input logic [3:0] s);
		logic [7:0] c;
		c = CH_NONE;
		case (s) inside
			4'd0, 4'd6, 4'd8, 4'd10: c = CH_COMMA;
			4'd4: c = CH_DOT;
			default: c = CH_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] step_width(input logic [3:0] s);
		logic [2:0] w;
		w = 3'd0;
		case (s) inside
			4'd1, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9: w = 3'd2;
			4'd11: w = 3'd4;
			default: w = 3'd0;
		endcase
		return w;
	endfunction

	function automatic logic [2:0] step_slot(input logic [3:0] s);
		logic [2:0] k;
		k = SLOT_NONE;
		case (s)
			4'd1: k = 3'd0;
			4'd2: k = 3'd1;
			4'd3: k = 3'd2;
			4'd7: k = 3'd3;
			4'd9: k = 3'd4;
			4'd11: k = SLOT_YEAR;
			default: k = SLOT_NONE;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

[rtl/core/nmea_zda_sentence_parser_core.sv]
// ZDA time sentence parser. Takes one received serial byte per request on the input
// channel and parses NMEA sentences on the fly, with no sentence buffer: a '$' restarts
// the sentence, a "$GPZDA" sentence is checked against "$GPZDA,hhmmss.ff,dd,mm,yyyy" as
// its bytes arrive, and a line feed reports it. With capture_enable set, a line feed
// ends the sentence and gives status 0 (time valid, with hour..year), 1 (no fix) or 2
// (malformed); a line feed closing any other sentence gives status 3 (reconfigure),
// with or without capture. Rate: one byte per clock while the input is not held off; the
// whole per-byte update is one pass of combinational logic between the parse state
// registers and a single result register, so a result appears in the cycle after its line
// feed is taken. The input is held off only while a result sits unread in that register.
`default_nettype none

module nmea_zda_sentence_parser_core
	import nzp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        capture_enable,
	// byte input
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	// result output
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [6:0]       hour,
	output logic [6:0]       minute,
	output logic [6:0]       second,
	output logic [6:0]       day,
	output logic [6:0]       month,
	output logic [13:0]      year
);

	// Parse state
	logic             capture_q;
	logic [POS_W-1:0] pos_q, pos_n;
	logic             pm_q, pm_n;       // "$GPZDA" tag still matching
	logic             nm_q, nm_n;       // no-fix pattern still matching
	logic [3:0]       fn_q, fn_n;       // parse step
	logic [2:0]       dc_q, dc_n;       // digits taken in current field
	logic             fail_q, fail_n;
	logic [6:0]       time_q [TIME_FIELDS];
	logic [6:0]       time_n [TIME_FIELDS];
	logic [13:0]      year_q, year_n;

	// Result register
	logic             out_valid_q;
	status_t          status_q;
	logic [6:0]       hour_q, minute_q, second_q, day_q, month_q;
	logic [13:0]      year_out_q;

	logic             in_fire;
	logic [POS_W-1:0] p;
	logic             is_digit;
	logic [3:0]       digit;
	logic [2:0]       slot;
	logic             res_valid;
	status_t          res_status;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire = in_valid && in_ready;
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign digit = rx_byte[3:0];

	always_comb begin
		pos_n = pos_q;
		pm_n = pm_q;
		nm_n = nm_q;
		fn_n = fn_q;
		dc_n = dc_q;
		fail_n = fail_q;
		time_n = time_q;
		year_n = year_q;
		p = pos_q;
		slot = SLOT_NONE;
		res_valid = 1'b0;
		res_status = STATUS_OTHER;

		if (in_fire) begin
			if (pos_q >= POS_W'(BUFFER_DEPTH)) begin
				// overflow: byte dropped, even a line feed
				pos_n = '0;
			end else begin
				if (rx_byte == CH_DOLLAR) begin
					p = '0;
				end
				if (p == '0) begin
					pm_n = 1'b1;
					nm_n = 1'b1;
					fn_n = '0;
					dc_n = '0;
					fail_n = 1'b0;
					for (int i = 0; i < TIME_FIELDS; i++) begin
						time_n[i] = '0;
					end
					year_n = '0;
				end
				pos_n = p + POS_W'(1);

				if (p < POS_W'(ZDA_LEN) && rx_byte != NOFIX_TAG[p[3:0]]) begin
					pm_n = 1'b0;
				end
				if (p < POS_W'(NOFIX_LEN) && rx_byte != NOFIX_TAG[p[3:0]]) begin
					nm_n = 1'b0;
				end

				// Field parser: at most two steps look at the same byte
				if (p >= POS_W'(ZDA_LEN) && pm_n && !fail_n && fn_n < STEP_DONE) begin
					if (step_lit(fn_n) != CH_NONE) begin
						if (rx_byte == step_lit(fn_n)) begin
							fn_n = fn_n + 4'd1;
						end else begin
							fail_n = 1'b1;
						end
					end else if (is_digit) begin
						slot = step_slot(fn_n);
						for (int i = 0; i < TIME_FIELDS; i++) begin
							if (slot == 3'(i)) begin
								time_n[i] = time_n[i] * 7'd10 + {3'b000, digit};
							end
						end
						if (slot == SLOT_YEAR) begin
							year_n = year_n * 14'd10 + {10'b0, digit};
						end
						dc_n = dc_n + 3'd1;
						if (dc_n >= step_width(fn_n)) begin
							fn_n = fn_n + 4'd1;
							dc_n = '0;
						end
					end else if (dc_n == '0) begin
						fail_n = 1'b1;
					end else begin
						// short field closed by a non-digit; next step sees the same byte
						fn_n = fn_n + 4'd1;
						dc_n = '0;
						if (fn_n != STEP_DONE) begin
							if (step_lit(fn_n) != CH_NONE && rx_byte == step_lit(fn_n)) begin
								fn_n = fn_n + 4'd1;
							end else begin
								fail_n = 1'b1;
							end
						end
					end
				end

				if (rx_byte == CH_LF) begin
					if (!pm_n) begin
						if (capture_q) begin
							pos_n = '0;
						end
						res_valid = 1'b1;
						res_status = STATUS_OTHER;
					end else if (capture_q) begin
						pos_n = '0;
						res_valid = 1'b1;
						if (!fail_n && fn_n >= STEP_DONE) begin
							res_status = STATUS_TIME_OK;
						end else if (nm_n) begin
							res_status = STATUS_NO_FIX;
						end else begin
							res_status = STATUS_MALFORMED;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_q <= 1'b0;
			pos_q <= '0;
			pm_q <= 1'b0;
			nm_q <= 1'b0;
			fn_q <= '0;
			dc_q <= '0;
			fail_q <= 1'b0;
			for (int i = 0; i < TIME_FIELDS; i++) begin
				time_q[i] <= '0;
			end
			year_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				capture_q <= capture_enable;
			end
			pos_q <= pos_n;
			pm_q <= pm_n;
			nm_q <= nm_n;
			fn_q <= fn_n;
			dc_q <= dc_n;
			fail_q <= fail_n;
			time_q <= time_n;
			year_q <= year_n;
			if (in_fire) begin
				out_valid_q <= res_valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; fields read zero unless the time is valid
	always_ff @(posedge clk) begin
		if (in_fire && res_valid) begin
			status_q <= res_status;
			if (res_status == STATUS_TIME_OK) begin
				hour_q <= time_n[0];
				minute_q <= time_n[1];
				second_q <= time_n[2];
				day_q <= time_n[3];
				month_q <= time_n[4];
				year_out_q <= year_n;
			end else begin
				hour_q <= '0;
				minute_q <= '0;
				second_q <= '0;
				day_q <= '0;
				month_q <= '0;
				year_out_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign hour = hour_q;
	assign minute = minute_q;
	assign second = second_q;
	assign day = day_q;
	assign month = month_q;
	assign year = year_out_q;

endmodule

`default_nettype wire

[rtl/core/nzp_checker.sv]
`include "nmea_zda_sentence_parser_core_macros.svh"
`default_nettype none

module nzp_checker
	import nzp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [7:0]  rx_byte,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [6:0]  hour,
	input wire logic [6:0]  minute,
	input wire logic [6:0]  second,
	input wire logic [6:0]  day,
	input wire logic [6:0]  month,
	input wire logic [13:0] year
);

	// a stalled result holds
	`NZP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(year), "result changed while stalled")

	// only a line feed can raise a result
	`NZP_ASSERT_NEXT(a_lf_only, clk, arst_n, (!out_valid || out_ready) && !(in_valid && in_ready && rx_byte == CH_LF), !out_valid, "result without a line feed")

	// one result register: a pending unread result blocks input
	`NZP_ASSERT(a_backpressure, clk, arst_n, out_valid && !out_ready, !in_ready, "input taken over a pending result")

	// time fields are zero unless the time is valid
	`NZP_ASSERT(a_zero_fields, clk, arst_n, out_valid && status != STATUS_TIME_OK, hour == 7'd0 && minute == 7'd0 && second == 7'd0 && day == 7'd0 && month == 7'd0 && year == 14'd0, "nonzero fields on a non-time result")

endmodule

bind nmea_zda_sentence_parser_core nzp_checker u_nzp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.rx_byte   (rx_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.hour      (hour),
	.minute    (minute),
	.second    (second),
	.day       (day),
	.month     (month),
	.year      (year)
);

`default_nettype wire
